// ===== hw/rtl/fap_pkg.sv =====
// Shared constants, operation and error codes, and pipeline stage types
// for the fixed-point ALU. No dependencies.
package fap_pkg;

  localparam int FRACTION_BITS = 12;
  localparam int WORD_BITS     = 32;
  localparam int OPND_BITS     = (WORD_BITS < 32) ? WORD_BITS : 32;
  // Dividend width: a 32-bit magnitude shifted left by the fraction bits.
  localparam int DW            = 32 + FRACTION_BITS;
  localparam logic [30:0] LIMIT_RESET = 31'h7FFF_FFFF;

  localparam logic [3:0] OP_MUL   = 4'd0;
  localparam logic [3:0] OP_FDIV  = 4'd1;
  localparam logic [3:0] OP_IDIV  = 4'd2;
  localparam logic [3:0] OP_MOD   = 4'd3;
  localparam logic [3:0] OP_REM   = 4'd4;
  localparam logic [3:0] OP_CEIL  = 4'd5;
  localparam logic [3:0] OP_FLOOR = 4'd6;
  localparam logic [3:0] OP_TRUNC = 4'd7;
  localparam logic [3:0] OP_ROUND = 4'd8;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  // Payload carried through the front stage and the divider stages.
  typedef struct packed {
    logic [3:0]        op;
    logic              sa;       // sign of operand a
    logic              sb;       // sign of operand b
    logic              div0;
    logic              rnd_ovf;  // round: the sum with one half is already beyond the limit
    logic signed [63:0] val;     // result of the non-divide operations
    logic [31:0]       dv;       // divisor magnitude
    logic [31:0]       rem;      // partial remainder
    logic [DW-1:0]     dq;       // dividend bits shifting out, quotient bits shifting in
  } fap_stage_t;

endpackage

// ===== hw/rtl/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU: input, divider chain and result
// stages. Depends on fap_pkg, fap_front, fap_div_step and fap_back.
//
// Usage: each word on the in_ channel carries an operation code and two raw
// signed operands; exactly one word leaves on the out_ channel for each,
// in order, carrying the result and an error code. The cfg_ channel writes
// the overflow limit; it is always ready and should be written only while
// no operation is in flight.
// The pipeline holds 48 register stages: an input register, the operand
// stage (one 32x32 multiply), 44 restoring divider stages that each resolve
// one quotient bit, a sign/magnitude stage and the output register. The input
// register loads at the accepting edge; out_tvalid rises when the word
// reaches the output register. Every operation walks the full chain, whose
// length sets the latency; throughput is one word per cycle while nothing stalls.
// The whole pipeline advances together. When the receiver stalls with a
// result on the output, all stages hold and in_tready drops; empty stages
// still let words in as long as the output is free or taken.
// Reset (synchronous, active low) empties the pipeline and restores the
// overflow limit to its largest value.
module fixed_point_alu import fap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // op[3:0], operand_a[35:4], operand_b[67:36], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result[31:0], error[33:32], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data    // overflow_limit
);

  logic        en;
  logic [30:0] limit_r;
  logic        vld_w [0:DW];
  fap_stage_t  st_w  [0:DW];
  logic [31:0] result;
  logic [1:0]  error;

  // Global advance: move whenever the output word is absent or being taken.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  fap_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_tvalid),
    .op_i  (in_tdata[3:0]),
    .a_i   (in_tdata[35:4]),
    .b_i   (in_tdata[67:36]),
    .limit (limit_r),
    .vld_o (vld_w[0]),
    .st_o  (st_w[0])
  );

  // One divider stage per dividend bit, most significant bit first.
  for (genvar i = 0; i < DW; i++) begin : g_div
    fap_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_w[i]),
      .st_i  (st_w[i]),
      .vld_o (vld_w[i+1]),
      .st_o  (st_w[i+1])
    );
  end

  fap_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_w[DW]),
    .st_i   (st_w[DW]),
    .limit  (limit_r),
    .vld_o  (out_tvalid),
    .result (result),
    .error  (error)
  );

  assign out_tdata = {6'd0, error, result};

endmodule

// ===== hw/rtl/fap_front.sv =====
// Input register and operand stage: multiply, rounding ops and divider setup.
// Depends on fap_pkg.
module fap_front import fap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [3:0]  op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [30:0] limit,
  output logic        vld_o,
  output fap_stage_t  st_o
);

  logic        v0_r;
  logic [3:0]  op0_r;
  logic [31:0] a0_r, b0_r;
  logic        v1_r;
  fap_stage_t  st1_r, st1_nxt;

  logic signed [31:0] a, b;
  logic [31:0]        aabs, babs;
  logic signed [63:0] prod, flr;
  logic               fr_nz;
  logic signed [32:0] sum;
  logic [32:0]        sum_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= vld_i;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= op_i;
      a0_r  <= a_i;
      b0_r  <= b_i;
      st1_r <= st1_nxt;
    end
  end

  always_comb begin
    a       = $signed(a0_r << (32 - OPND_BITS)) >>> (32 - OPND_BITS);
    b       = $signed(b0_r << (32 - OPND_BITS)) >>> (32 - OPND_BITS);
    aabs    = a[31] ? (~a + 32'sd1) : a;
    babs    = b[31] ? (~b + 32'sd1) : b;
    prod    = a * b;
    flr     = 64'(a) >>> FRACTION_BITS;
    fr_nz   = |a[FRACTION_BITS-1:0];
    sum     = 33'(a) + $signed(33'(1) << (FRACTION_BITS - 1));
    sum_mag = sum[32] ? (~sum + 33'sd1) : sum;

    st1_nxt         = '0;
    st1_nxt.op      = op0_r;
    st1_nxt.sa      = a[31];
    st1_nxt.sb      = b[31];
    st1_nxt.div0    = (op0_r >= OP_FDIV) && (op0_r <= OP_REM) && (b == 32'sd0);
    st1_nxt.dv      = babs;
    st1_nxt.rem     = '0;
    st1_nxt.dq      = (op0_r == OP_FDIV) ? {aabs, {FRACTION_BITS{1'b0}}}
                                         : {{FRACTION_BITS{1'b0}}, aabs};
    st1_nxt.rnd_ovf = 1'b0;
    case (op0_r)
      OP_MUL:   st1_nxt.val = prod >>> FRACTION_BITS;
      OP_CEIL:  st1_nxt.val = flr + 64'(fr_nz);
      OP_FLOOR: st1_nxt.val = flr;
      OP_TRUNC: st1_nxt.val = flr + 64'(fr_nz && a[31]);
      OP_ROUND: begin
        st1_nxt.val     = 64'(sum) >>> FRACTION_BITS;
        st1_nxt.rnd_ovf = sum_mag > {2'b00, limit};
      end
      default:  st1_nxt.val = '0;
    endcase
  end

  assign vld_o = v1_r;
  assign st_o  = st1_r;

endmodule

// ===== hw/rtl/fap_div_step.sv =====
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on fap_pkg.
module fap_div_step import fap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_i,
  input  fap_stage_t st_i,
  output logic       vld_o,
  output fap_stage_t st_o
);

  logic       vld_r;
  fap_stage_t st_r, st_nxt;
  logic [32:0] t, diff;
  logic        ge;

  always_comb begin
    t      = {st_i.rem, st_i.dq[DW-1]};
    diff   = t - {1'b0, st_i.dv};
    ge     = t >= {1'b0, st_i.dv};
    st_nxt = st_i;
    st_nxt.rem = ge ? diff[31:0] : t[31:0];
    st_nxt.dq  = {st_i.dq[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;

endmodule

// ===== hw/rtl/fap_back.sv =====
// Result stages: sign and magnitude of each operation, then limit check
// and the output register. Depends on fap_pkg.
module fap_back import fap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  fap_stage_t  st_i,
  input  logic [30:0] limit,
  output logic        vld_o,
  output logic [31:0] result,
  output logic [1:0]  error
);

  logic        va_r, vb_r;
  logic        div0_r, ovf_r, neg_r, neg_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [63:0] q;

  always_comb begin
    q       = 64'(st_i.dq);
    neg_nxt = 1'b0;
    mag_nxt = '0;
    case (st_i.op)
      OP_FDIV, OP_IDIV: begin
        neg_nxt = st_i.sa ^ st_i.sb;
        mag_nxt = q;
      end
      OP_REM: begin
        neg_nxt = st_i.sa;
        mag_nxt = 64'(st_i.rem);
      end
      OP_MOD: begin
        if (st_i.rem == '0) begin
          mag_nxt = '0;
        end else if (st_i.sa != st_i.sb) begin
          neg_nxt = st_i.sb;
          mag_nxt = 64'(st_i.dv - st_i.rem);
        end else begin
          neg_nxt = st_i.sa;
          mag_nxt = 64'(st_i.rem);
        end
      end
      default: begin
        neg_nxt = st_i.val[63];
        mag_nxt = st_i.val[63] ? 64'(-st_i.val) : 64'(st_i.val);
      end
    endcase
  end

  always_comb begin
    if (div0_r) begin
      err_nxt = ERR_DIV0;
    end else if (ovf_r || (mag_r > 64'(limit))) begin
      err_nxt = ERR_OVF;
    end else begin
      err_nxt = ERR_NONE;
    end
    if (err_nxt != ERR_NONE) begin
      res_nxt = '0;
    end else begin
      res_nxt = neg_r ? (32'd0 - mag_r[31:0]) : mag_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= vld_i;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div0_r <= st_i.div0;
      ovf_r  <= st_i.rnd_ovf;
      neg_r  <= neg_nxt;
      mag_r  <= mag_nxt;
      res_r  <= res_nxt;
      err_r  <= err_nxt;
    end
  end

  assign vld_o  = vb_r;
  assign result = res_r;
  assign error  = err_r;

endmodule

// ===== hw/rtl/fap_checker.sv =====
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fap_pkg and fixed_point_alu.
module fap_props import fap_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:32] == ERR_NONE || out_tdata[33:32] == ERR_DIV0 ||
                    out_tdata[33:32] == ERR_OVF))
    else $error("undefined error code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] != ERR_NONE) |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero result with error");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output word changed");

endmodule

bind fixed_point_alu fap_props u_fap_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/fap_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the fixed-point ALU: watches the in_, out_ and cfg_
// channels, predicts each result and compares it. Depends on fap_pkg.
module fap_checker import fap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  typedef struct packed {
    logic [1:0]  error;
    logic [31:0] result;
  } alu_result_t;

  alu_result_t       expected_results[$];
  logic        [30:0] limit_now;

  function automatic bit exceeds(longint v, logic [30:0] lim);
    longint mag;
    mag = (v < 0) ? -v : v;
    return mag > longint'(lim);
  endfunction

  function automatic alu_result_t compute_alu(logic [3:0] op, logic signed [31:0] a_in,
                                              logic signed [31:0] b_in, logic [30:0] lim);
    longint      a, b, r, unit, sum;
    alu_result_t res;
    a = a_in;
    b = b_in;
    unit = longint'(1) <<< FRACTION_BITS;
    r = 0;
    res.error = ERR_NONE;
    if (op >= OP_FDIV && op <= OP_REM && b == 0) begin
      res.error = ERR_DIV0;
    end else begin
      case (op)
        OP_MUL:   r = (a * b) >>> FRACTION_BITS;
        OP_FDIV:  r = (a * unit) / b;
        OP_IDIV:  r = a / b;
        OP_MOD: begin
          r = a % b;
          if (r != 0 && ((r < 0) != (b < 0))) r = r + b;
        end
        OP_REM:   r = a % b;
        OP_CEIL, OP_TRUNC: begin
          r = a >>> FRACTION_BITS;
          if ((a & (unit - 1)) != 0 && (op == OP_CEIL || a < 0)) r = r + 1;
        end
        OP_FLOOR: r = a >>> FRACTION_BITS;
        OP_ROUND: begin
          sum = a + (unit >>> 1);
          if (exceeds(sum, lim)) res.error = ERR_OVF;
          r = sum >>> FRACTION_BITS;
        end
        default:  r = 0;
      endcase
      if (res.error == ERR_NONE && exceeds(r, lim)) res.error = ERR_OVF;
    end
    if (res.error != ERR_NONE) r = 0;
    res.result = r[31:0];
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    alu_result_t got, want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      limit_now <= LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) limit_now <= cfg_data;
      if (in_tvalid && in_tready)
        expected_results.push_back(compute_alu(in_tdata[3:0], in_tdata[35:4],
                                               in_tdata[67:36], limit_now));
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        got.result = out_tdata[31:0];
        got.error  = out_tdata[33:32];
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          errs = errs + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.result !== want.result) begin
            $error("result: expected %h, actual %h", want.result, got.result);
            errs = errs + 1;
          end
          if (got.error !== want.error) begin
            $error("error: expected %0d, actual %0d", want.error, got.error);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

  initial begin
    fail_count   = 0;
    result_count = 0;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the fixed-point ALU testbench: clock, reset, stimulus and verdict.
// Depends on fap_pkg, fixed_point_alu and fap_checker.
module testbench;
  import fap_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          word_count;
  bit          steady;  // while set, neither side idles

  fixed_point_alu i_dut (.*);

  fap_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The receiver stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= steady || ($urandom_range(99) >= 27);
  end

  // Random operand with a bias toward the interesting corners.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(8191) - 4096;
      3: return {{20{$urandom_range(1) == 1}}, 12'($urandom)};
      4: return 32'($urandom_range(3)) << FRACTION_BITS;
      default: return $urandom;
    endcase
  endfunction

  // Drives one word, holding it until accepted; idle cycles may come first.
  task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    while (!steady && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b, a, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    word_count++;
  endtask

  // Waits for every result, then lets the pipeline drain before a write.
  task automatic write_limit(logic [30:0] value);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
      send_word(op, pick_operand(), ($urandom_range(15) == 0) ? 32'd0 : pick_operand());
    end
  endtask

  initial begin
    logic [30:0] limits[4];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    steady     = 1'b0;
    word_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: field extremes, every op, divide by zero, overflow
    // on each divide, round overflow near the top and unused op codes.
    send_word(OP_MUL,   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(OP_MUL,   32'h8000_0000, 32'h8000_0000);
    send_word(OP_MUL,   32'hFFFF_F800, 32'h0000_1800);
    send_word(OP_FDIV,  32'h0010_0000, 32'd1);
    send_word(OP_FDIV,  32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_FDIV,  32'd5, 32'd0);
    send_word(OP_IDIV,  32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_IDIV,  32'hFFFF_FFF9, 32'd2);
    send_word(OP_IDIV,  32'd7, 32'd0);
    send_word(OP_MOD,   32'hFFFF_FFF9, 32'd2);
    send_word(OP_MOD,   32'd7, 32'hFFFF_FFFE);
    send_word(OP_MOD,   32'd7, 32'd0);
    send_word(OP_REM,   32'hFFFF_FFF9, 32'd2);
    send_word(OP_REM,   32'h8000_0000, 32'd0);
    send_word(OP_CEIL,  32'hFFFF_F001, 32'd0);
    send_word(OP_CEIL,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_FLOOR, 32'h8000_0000, 32'd0);
    send_word(OP_TRUNC, 32'hFFFF_E801, 32'd0);
    send_word(OP_ROUND, 32'h7FFF_FFFF, 32'd0);
    send_word(OP_ROUND, 32'h0000_0800, 32'd0);
    send_word(OP_ROUND, 32'hFFFF_F7FF, 32'd0);
    send_word(4'd9,     32'h1234_5678, 32'd3);
    send_word(4'd15,    32'hFFFF_FFFF, 32'hFFFF_FFFF);

    limits = '{31'd0, 31'd4096, 31'($urandom), 31'h7FFF_FFFF};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      // Small limits make overflow common; a small divide probes it directly.
      send_word(OP_FDIV, 32'd3, 32'd2);
      random_phase(270);
      steady = 1'b1;
      random_phase(100);
      steady = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d words over all nine ops, unused codes and four overflow limits;",
             word_count);
    $display("checked %0d results with random stalls on both channels.", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
